// ----- rtl/tbk_pkg.sv -----
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Token bucket package
// Widths, reset values, request and register codes, FSM states and the
// structs that pass between the token bucket modules.
// ----------------------------------------------------------------------------
package tbk_pkg;

  // Number of users and fixed-point format of a level.
  localparam int USERS      = 16;
  localparam int FRAC_BITS  = 16;

  // Field widths.
  localparam int LEVEL_W    = 32;
  localparam int SIZE_W     = 16;
  localparam int PERIOD_W   = 32;
  localparam int ELAPSED_W  = 32;
  localparam int TOKENS_W   = 16;
  localparam int USER_IDX_W = 4;
  localparam int REQ_W      = 2;
  localparam int CFG_IDX_W  = 4;
  localparam int CFG_DATA_W = 32;

  // Memory address width and a wide index used for the range check.
  localparam int USER_W     = (USERS > 1) ? $clog2(USERS) : 1;
  localparam int IDX_EXT_W  = ((USER_W > USER_IDX_W) ? USER_W : USER_IDX_W) + 1;

  // Divider and cap widths.
  localparam int DIVIDEND_W = ELAPSED_W + FRAC_BITS;
  localparam int DIV_CNT_W  = $clog2(DIVIDEND_W + 1);
  localparam int CAP_EXT_W  = LEVEL_W + FRAC_BITS;

  // Reset values of the registers and of every bucket.
  localparam int unsigned RESET_SIZE   = 50;
  localparam int unsigned RESET_PERIOD = 200000;
  localparam logic [LEVEL_W-1:0] RESET_LEVEL =
    LEVEL_W'(64'(RESET_SIZE) << FRAC_BITS);
  localparam logic [LEVEL_W-1:0] ONE_TOKEN = LEVEL_W'(64'(1) << FRAC_BITS);

  // Request codes; the fourth code only reports a level.
  typedef enum logic [REQ_W-1:0] {
    REQ_TICK = 2'd0,
    REQ_GET  = 2'd1,
    REQ_INIT = 2'd2
  } req_type_t;

  // Configuration register indexes.
  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_BUCKET_SIZE  = 4'd0,
    CFG_TOKEN_PERIOD = 4'd1
  } cfg_reg_t;

  // Control sequencer states.
  typedef enum logic [2:0] {
    S_IDLE,
    S_READ,
    S_MOD,
    S_DIV_GO,
    S_DIV_WAIT,
    S_WALK_RD,
    S_WALK_WR,
    S_OUT
  } state_t;

  // Access to the level memory.
  typedef struct packed {
    logic               we;
    logic [USER_W-1:0]  waddr;
    logic [LEVEL_W-1:0] wdata;
    logic [USER_W-1:0]  raddr;
  } ram_req_t;

  // Divider command and response.
  typedef struct packed {
    logic                  start;
    logic [DIVIDEND_W-1:0] dividend;
    logic [PERIOD_W-1:0]   divisor;
  } div_cmd_t;

  typedef struct packed {
    logic               done;
    logic [LEVEL_W-1:0] quotient;
  } div_rsp_t;

endpackage
`default_nettype wire

// ----- rtl/tbk_ifs.sv -----
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Token bucket channels
// Valid/ready channels for requests, results and configuration writes.
// ----------------------------------------------------------------------------

// Request channel.
interface tbk_req_if import tbk_pkg::*; ();
  logic                  valid;
  logic                  ready;
  logic [REQ_W-1:0]      req_type;
  logic [USER_IDX_W-1:0] user_index;
  logic [ELAPSED_W-1:0]  elapsed_us;

  modport source (output valid, req_type, user_index, elapsed_us, input ready);
  modport sink   (input valid, req_type, user_index, elapsed_us, output ready);
endinterface

// Result channel.
interface tbk_rsp_if import tbk_pkg::*; ();
  logic                valid;
  logic                ready;
  logic                granted;
  logic [TOKENS_W-1:0] level_tokens;

  modport source (output valid, granted, level_tokens, input ready);
  modport sink   (input valid, granted, level_tokens, output ready);
endinterface

// Configuration write channel.
interface tbk_cfg_if import tbk_pkg::*; ();
  logic                  valid;
  logic                  ready;
  logic [CFG_IDX_W-1:0]  index;
  logic [CFG_DATA_W-1:0] data;

  modport source (output valid, index, data, input ready);
  modport sink   (input valid, index, data, output ready);
endinterface
`default_nettype wire

// ----- rtl/tbk_div.sv -----
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Token bucket refill divider
// Restoring divider, one quotient bit per cycle, with the quotient
// saturated to the level width.
// ----------------------------------------------------------------------------
module tbk_div import tbk_pkg::*; (
  input  wire logic     clk,
  input  wire logic     rst,
  input  wire div_cmd_t cmd,
  output div_rsp_t      rsp
);

  logic                  busy;
  logic                  done;
  logic [DIV_CNT_W-1:0]  cnt;
  logic [DIVIDEND_W-1:0] quo;
  logic [PERIOD_W-1:0]   rem;
  logic [PERIOD_W-1:0]   dsr;
  logic [PERIOD_W:0]     rem_sh;
  logic [PERIOD_W:0]     diff;
  logic                  fits;

  // Shift in the next dividend bit and trial-subtract the divisor.
  always_comb begin
    rem_sh = {rem, quo[DIVIDEND_W-1]};
    fits   = rem_sh >= {1'b0, dsr};
    diff   = rem_sh - {1'b0, dsr};
  end

  // Control of the iteration.
  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= 1'b0;
      if (cmd.start) begin
        busy <= 1'b1;
        cnt  <= '0;
      end else if (busy) begin
        cnt <= cnt + 1'b1;
        if (cnt == DIV_CNT_W'(DIVIDEND_W - 1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  // Remainder and quotient shift register.
  always_ff @(posedge clk) begin
    if (cmd.start) begin
      quo <= cmd.dividend;
      rem <= '0;
      dsr <= cmd.divisor;
    end else if (busy) begin
      rem <= fits ? diff[PERIOD_W-1:0] : rem_sh[PERIOD_W-1:0];
      quo <= {quo[DIVIDEND_W-2:0], fits};
    end
  end

  // Saturate the quotient to the level width.
  always_comb begin
    rsp.done     = done;
    rsp.quotient = (|(quo >> LEVEL_W)) ? '1 : quo[LEVEL_W-1:0];
  end

  // A result is only reported at the end of a running division.
  a_done_after_busy: assert property (@(posedge clk) disable iff (rst)
    done |-> $past(busy))
    else $error("divider done without a running division");

endmodule
`default_nettype wire

// ----- rtl/tbk_ram.sv -----
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Token bucket level memory
// One write and one registered read port. A per-entry valid bit makes an
// entry that was not written since reset read as a full bucket.
// ----------------------------------------------------------------------------
module tbk_ram import tbk_pkg::*; (
  input  wire logic     clk,
  input  wire logic     rst,
  input  wire ram_req_t req,
  output logic [LEVEL_W-1:0] rd_data
);

  logic [LEVEL_W-1:0] mem [USERS];
  logic [USERS-1:0]   vld;
  logic [LEVEL_W-1:0] rd_mem;
  logic               rd_hit;

  // Storage and registered read.
  always_ff @(posedge clk) begin
    if (req.we) begin
      mem[req.waddr] <= req.wdata;
    end
    rd_mem <= mem[req.raddr];
  end

  // Valid bits, cleared at reset.
  always_ff @(posedge clk) begin
    if (rst) begin
      vld    <= '0;
      rd_hit <= 1'b0;
    end else begin
      if (req.we) begin
        vld[req.waddr] <= 1'b1;
      end
      rd_hit <= vld[req.raddr];
    end
  end

  // An entry never written holds the reset level.
  assign rd_data = rd_hit ? rd_mem : RESET_LEVEL;

endmodule
`default_nettype wire

// ----- rtl/multi_user_token_bucket.sv -----
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Multi-user token bucket
// Per-user token levels in fixed point, refilled by elapsed time and
// taken one token at a time.
// ----------------------------------------------------------------------------
// Usage:
//   req carries one item: req_type, user_index and elapsed_us. rsp returns
//   one item per request: granted and the integer level_tokens of the
//   addressed user. cfg writes bucket_size (index 0) or token_period_us
//   (index 1); it is always ready. It must be written only while the block
//   is idle; the block itself does not enforce this. A get, init or report
//   item passes the read, modify and result states, and get and init write
//   the level back to memory. A tick first divides elapsed_us scaled by the
//   fraction bits by the token period in a bit-serial divider, then walks
//   all users with a read state and a write state each.
//   One item is in work at a time; the next is accepted once the result has
//   moved into the output register, so a result waiting on rsp does not stop
//   the next item from entering.
//   When the receiver stalls, the result holds in the output register and
//   the following result waits in the sequencer until the register is free.
//   Reset restores the register defaults and marks every bucket full at the
//   default size; it takes effect with no clearing pass.
// ----------------------------------------------------------------------------
module multi_user_token_bucket import tbk_pkg::*; (
  input  wire logic clk,
  input  wire logic rst,
  tbk_req_if.sink   req,
  tbk_rsp_if.source rsp,
  tbk_cfg_if.sink   cfg
);

  state_t state;
  state_t state_next;

  // Configuration registers.
  logic [SIZE_W-1:0]   bucket_size;
  logic [PERIOD_W-1:0] token_period;

  // Captured request.
  req_type_t            req_r;
  logic [USER_W-1:0]    addr_r;
  logic                 user_ok_r;
  logic [ELAPSED_W-1:0] elapsed_r;

  // Refill increment and walk position.
  logic [LEVEL_W-1:0] inc_r;
  logic [USER_W-1:0]  walk_idx;

  // Pending result and output register.
  logic                res_granted;
  logic [TOKENS_W-1:0] res_level;
  logic                rsp_valid;
  logic                rsp_granted;
  logic [TOKENS_W-1:0] rsp_level;

  // Datapath signals.
  logic [IDX_EXT_W-1:0] idx_ext;
  logic [CAP_EXT_W-1:0] cap_ext;
  logic [LEVEL_W-1:0]   cap_level;
  logic [LEVEL_W-1:0]   rd_level;
  logic [LEVEL_W:0]     walk_sum;
  logic [LEVEL_W-1:0]   walk_level;
  logic                 get_ok;
  logic [LEVEL_W-1:0]   mod_level;
  logic                 walk_last;
  logic                 in_take;
  logic                 out_free;
  ram_req_t             ram_req;
  div_cmd_t             div_cmd;
  div_rsp_t             div_rsp;

  tbk_ram u_ram (
    .clk     (clk),
    .rst     (rst),
    .req     (ram_req),
    .rd_data (rd_level)
  );

  tbk_div u_div (
    .clk (clk),
    .rst (rst),
    .cmd (div_cmd),
    .rsp (div_rsp)
  );

  // Handshake terms.
  assign in_take   = req.valid && req.ready;
  assign out_free  = !rsp_valid || rsp.ready;
  assign walk_last = walk_idx == USER_W'(USERS - 1);
  assign idx_ext   = IDX_EXT_W'(req.user_index);

  // Level cap, saturated to the level width.
  always_comb begin
    cap_ext   = CAP_EXT_W'(bucket_size) << FRAC_BITS;
    cap_level = (|(cap_ext >> LEVEL_W)) ? '1 : cap_ext[LEVEL_W-1:0];
  end

  // Refill of one bucket during the walk.
  always_comb begin
    walk_sum   = {1'b0, rd_level} + {1'b0, inc_r};
    walk_level = (walk_sum > {1'b0, cap_level}) ? cap_level : walk_sum[LEVEL_W-1:0];
  end

  // Get, init or report on the addressed bucket.
  always_comb begin
    get_ok = rd_level >= ONE_TOKEN;
    case (req_r)
      REQ_GET:  mod_level = get_ok ? rd_level - ONE_TOKEN : rd_level;
      REQ_INIT: mod_level = cap_level;
      default:  mod_level = rd_level;
    endcase
  end

  // Next state.
  always_comb begin
    state_next = state;
    case (state)
      S_IDLE: begin
        if (req.valid) begin
          state_next = (req_type_t'(req.req_type) == REQ_TICK) ? S_DIV_GO : S_READ;
        end
      end
      S_READ:     state_next = S_MOD;
      S_MOD:      state_next = S_OUT;
      S_DIV_GO:   state_next = S_DIV_WAIT;
      S_DIV_WAIT: state_next = div_rsp.done ? S_WALK_RD : S_DIV_WAIT;
      S_WALK_RD:  state_next = S_WALK_WR;
      S_WALK_WR:  state_next = walk_last ? S_OUT : S_WALK_RD;
      S_OUT:      state_next = out_free ? S_IDLE : S_OUT;
      default:    state_next = S_IDLE;
    endcase
  end

  // Outputs of the sequencer: handshake, memory access and divider start.
  always_comb begin
    req.ready        = 1'b0;
    ram_req.we       = 1'b0;
    ram_req.waddr    = addr_r;
    ram_req.wdata    = mod_level;
    ram_req.raddr    = addr_r;
    div_cmd.start    = 1'b0;
    div_cmd.dividend = DIVIDEND_W'(elapsed_r) << FRAC_BITS;
    div_cmd.divisor  = (token_period == '0) ? PERIOD_W'(1) : token_period;
    case (state)
      S_IDLE:   req.ready = 1'b1;
      S_MOD: begin
        ram_req.we = user_ok_r && (req_r == REQ_GET || req_r == REQ_INIT);
      end
      S_DIV_GO: div_cmd.start = 1'b1;
      S_WALK_RD: begin
        ram_req.raddr = walk_idx;
      end
      S_WALK_WR: begin
        ram_req.we    = 1'b1;
        ram_req.waddr = walk_idx;
        ram_req.wdata = walk_level;
      end
      default: ;
    endcase
  end

  // State register.
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // Configuration registers; the port never stalls.
  assign cfg.ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      bucket_size  <= SIZE_W'(RESET_SIZE);
      token_period <= PERIOD_W'(RESET_PERIOD);
    end else if (cfg.valid) begin
      case (cfg_reg_t'(cfg.index))
        CFG_BUCKET_SIZE:  bucket_size  <= cfg.data[SIZE_W-1:0];
        CFG_TOKEN_PERIOD: token_period <= cfg.data[PERIOD_W-1:0];
        default: ;
      endcase
    end
  end

  // Request capture, refill walk and result build-up.
  always_ff @(posedge clk) begin
    if (in_take) begin
      req_r       <= req_type_t'(req.req_type);
      addr_r      <= idx_ext[USER_W-1:0];
      user_ok_r   <= idx_ext < IDX_EXT_W'(USERS);
      elapsed_r   <= req.elapsed_us;
      res_granted <= 1'b0;
      res_level   <= '0;
    end
    if (state == S_DIV_WAIT && div_rsp.done) begin
      inc_r    <= div_rsp.quotient;
      walk_idx <= '0;
    end
    if (state == S_WALK_WR) begin
      walk_idx <= walk_idx + 1'b1;
      if (user_ok_r && walk_idx == addr_r) begin
        res_level <= TOKENS_W'(walk_level >> FRAC_BITS);
      end
    end
    if (state == S_MOD) begin
      res_granted <= user_ok_r && req_r == REQ_GET && get_ok;
      res_level   <= user_ok_r ? TOKENS_W'(mod_level >> FRAC_BITS) : '0;
    end
  end

  // Output register.
  always_ff @(posedge clk) begin
    if (rst) begin
      rsp_valid <= 1'b0;
    end else if (state == S_OUT && out_free) begin
      rsp_valid <= 1'b1;
    end else if (rsp.ready) begin
      rsp_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (state == S_OUT && out_free) begin
      rsp_granted <= res_granted;
      rsp_level   <= res_level;
    end
  end

  assign rsp.valid        = rsp_valid;
  assign rsp.granted      = rsp_granted;
  assign rsp.level_tokens = rsp_level;

  // An accepted item starts either a lookup or a refill.
  a_accept_starts: assert property (@(posedge clk) disable iff (rst)
    in_take |=> (state == S_READ || state == S_DIV_GO))
    else $error("accepted item did not start work");

  // A refilled level never exceeds the cap.
  a_walk_capped: assert property (@(posedge clk) disable iff (rst)
    (state == S_WALK_WR) |-> (walk_level <= cap_level))
    else $error("refilled level above cap");

  // A new result appears only out of the result state.
  a_result_source: assert property (@(posedge clk) disable iff (rst)
    $rose(rsp_valid) |-> ($past(state) == S_OUT))
    else $error("result raised outside the result state");

endmodule
`default_nettype wire

// ----- tb/sv/testbench.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Multi-user token bucket testbench
// Drives token requests and register writes into the bucket block and
// checks every result against the directed table's value or a bench-side
// copy of the bucket levels. A directed table covers extremes and corner
// cases first. Random phases with new bucket sizes and token periods
// follow. Both channels idle at random.
// ----------------------------------------------------------------------------
module testbench;
  import tbk_pkg::*;

  // Request code that only reports a level, and the unused register indexes.
  localparam logic [REQ_W-1:0]     REQ_REPORT       = 2'd3;
  localparam logic [CFG_IDX_W-1:0] CFG_FIRST_UNUSED = 4'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_LAST_UNUSED  = 4'd15;
  localparam logic [LEVEL_W-1:0]   LEVEL_ALL_ONES   = '1;

  localparam int CYCLE_LIMIT  = 1500000;
  localparam int DRAIN_CYCLES = 120;
  localparam int PHASES       = 12;
  localparam int PHASE_ITEMS  = 128;

  typedef struct packed {
    logic                granted;
    logic [TOKENS_W-1:0] level_tokens;
  } bucket_result_t;

  // A directed row is either a register write or a request item.
  typedef struct {
    bit                    is_cfg;
    logic [CFG_IDX_W-1:0]  cfg_index;
    logic [CFG_DATA_W-1:0] cfg_data;
    logic [REQ_W-1:0]      kind;
    logic [USER_IDX_W-1:0] user;
    logic [ELAPSED_W-1:0]  elapsed;
    bit                    typed;
    bucket_result_t        want;
  } bench_row_t;

  // Typed expectation that travels with an item until it is accepted.
  typedef struct {
    bit             typed;
    bucket_result_t want;
  } row_check_t;

  logic clk;
  logic rst;

  tbk_req_if req_ch ();
  tbk_rsp_if rsp_ch ();
  tbk_cfg_if cfg_ch ();

  multi_user_token_bucket u_dut (
    .clk (clk),
    .rst (rst),
    .req (req_ch),
    .rsp (rsp_ch),
    .cfg (cfg_ch)
  );

  // Bench copy of the block state.
  logic [LEVEL_W-1:0]  levels_q16 [USERS];
  logic [SIZE_W-1:0]   size_reg;
  logic [PERIOD_W-1:0] period_reg;

  bucket_result_t awaited_results [$];
  row_check_t     row_checks [$];
  bench_row_t     directed_rows [$];

  int error_count;
  int cycle_count;
  bit sender_calm;

  // Clock.
  initial clk = 1'b0;
  always #4 clk = ~clk;

  // Level ceiling in fixed point, saturated to the level width.
  function automatic logic [LEVEL_W-1:0] level_ceiling();
    logic [CAP_EXT_W-1:0] wide;
    wide = CAP_EXT_W'(size_reg) << FRAC_BITS;
    if (wide > CAP_EXT_W'(LEVEL_ALL_ONES)) begin
      return LEVEL_ALL_ONES;
    end
    return wide[LEVEL_W-1:0];
  endfunction

  function automatic void restore_defaults();
    size_reg   = SIZE_W'(RESET_SIZE);
    period_reg = PERIOD_W'(RESET_PERIOD);
    for (int u = 0; u < USERS; u++) begin
      levels_q16[u] = level_ceiling();
    end
  endfunction

  // Applies one request to the bench levels and returns the result it yields.
  function automatic bucket_result_t apply_request(logic [REQ_W-1:0] kind,
                                                   logic [USER_IDX_W-1:0] user,
                                                   logic [ELAPSED_W-1:0] elapsed);
    bucket_result_t res;
    logic [63:0]    divisor;
    logic [63:0]    inc;
    logic [63:0]    sum;
    bit             in_range;
    in_range = int'(user) < USERS;
    res = '0;
    case (kind)
      REQ_TICK: begin
        divisor = (period_reg == 0) ? 64'd1 : 64'(period_reg);
        inc = (64'(elapsed) << FRAC_BITS) / divisor;
        if (inc > 64'(LEVEL_ALL_ONES)) begin
          inc = 64'(LEVEL_ALL_ONES);
        end
        for (int u = 0; u < USERS; u++) begin
          sum = 64'(levels_q16[u]) + inc;
          if (sum > 64'(level_ceiling())) begin
            sum = 64'(level_ceiling());
          end
          levels_q16[u] = sum[LEVEL_W-1:0];
        end
      end
      REQ_GET: begin
        if (in_range && levels_q16[user] >= ONE_TOKEN) begin
          levels_q16[user] = levels_q16[user] - ONE_TOKEN;
          res.granted = 1'b1;
        end
      end
      REQ_INIT: begin
        if (in_range) begin
          levels_q16[user] = level_ceiling();
        end
      end
      default: begin
      end
    endcase
    if (in_range) begin
      res.level_tokens = TOKENS_W'(levels_q16[user] >> FRAC_BITS);
    end
    return res;
  endfunction

  task automatic report_mismatch(string what, logic [31:0] want, logic [31:0] got);
    error_count++;
    if (error_count <= 10) begin
      $display("mismatch at %0t: %s expected %0h, got %0h", $realtime, what, want, got);
    end
  endtask

  // Tracks register writes and requests as they are accepted, and checks results.
  always @(posedge clk) begin : track
    bucket_result_t predicted;
    bucket_result_t want;
    row_check_t     check;
    if (!rst) begin
      if (cfg_ch.valid && cfg_ch.ready) begin
        case (cfg_ch.index)
          CFG_BUCKET_SIZE:  size_reg = cfg_ch.data[SIZE_W-1:0];
          CFG_TOKEN_PERIOD: period_reg = cfg_ch.data[PERIOD_W-1:0];
          default: begin
          end
        endcase
      end
      if (req_ch.valid && req_ch.ready) begin
        predicted = apply_request(req_ch.req_type, req_ch.user_index, req_ch.elapsed_us);
        check = row_checks.pop_front();
        awaited_results.push_back(check.typed ? check.want : predicted);
      end
      if (rsp_ch.valid && rsp_ch.ready) begin
        if (awaited_results.size() == 0) begin
          report_mismatch("unexpected item, level", 32'h0, 32'(rsp_ch.level_tokens));
        end else begin
          want = awaited_results.pop_front();
          if (rsp_ch.granted !== want.granted) begin
            report_mismatch("granted", 32'(want.granted), 32'(rsp_ch.granted));
          end
          if (rsp_ch.level_tokens !== want.level_tokens) begin
            report_mismatch("level_tokens", 32'(want.level_tokens),
                            32'(rsp_ch.level_tokens));
          end
        end
      end
    end
  end

  // Result side back-pressure: mostly short stalls, a few long ones, and calm
  // stretches with no stalls at all.
  always @(posedge clk) begin : rsp_stall
    int  stall_left;
    bit  calm;
    int  pick;
    if (cycle_count % 256 == 0) begin
      calm = ($urandom_range(0, 2) == 0);
    end
    if (stall_left > 0) begin
      stall_left--;
      rsp_ch.ready <= 1'b0;
    end else if (!calm && $urandom_range(0, 3) == 0) begin
      pick = $urandom_range(0, 19);
      stall_left = (pick == 0) ? $urandom_range(20, 60) : $urandom_range(0, 3);
      rsp_ch.ready <= 1'b0;
    end else begin
      rsp_ch.ready <= 1'b1;
    end
  end

  // Run limit.
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("testbench: done, errors");
      $finish;
    end
  end

  // Presents one item after a gap and returns at the edge that accepts it.
  task automatic send_item(logic [REQ_W-1:0] kind, logic [USER_IDX_W-1:0] user,
                           logic [ELAPSED_W-1:0] elapsed, int gap, bit typed,
                           bucket_result_t want);
    row_check_t check;
    if (gap > 0) begin
      req_ch.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    check.typed = typed;
    check.want  = want;
    row_checks.push_back(check);
    req_ch.valid      <= 1'b1;
    req_ch.req_type   <= kind;
    req_ch.user_index <= user;
    req_ch.elapsed_us <= elapsed;
    @(posedge clk);
    while (!req_ch.ready) @(posedge clk);
  endtask

  // Stops sending and waits for every outstanding result.
  task automatic drain_results();
    req_ch.valid <= 1'b0;
    @(posedge clk);
    while (awaited_results.size() != 0) @(posedge clk);
  endtask

  // Register write; the block is drained first so it is idle.
  task automatic write_register(logic [CFG_IDX_W-1:0] index, logic [CFG_DATA_W-1:0] data);
    drain_results();
    cfg_ch.valid <= 1'b1;
    cfg_ch.index <= index;
    cfg_ch.data  <= data;
    @(posedge clk);
    while (!cfg_ch.ready) @(posedge clk);
    cfg_ch.valid <= 1'b0;
  endtask

  function automatic void add_item(logic [REQ_W-1:0] kind, logic [USER_IDX_W-1:0] user,
                                   logic [ELAPSED_W-1:0] elapsed, bit typed,
                                   logic granted, logic [TOKENS_W-1:0] level);
    bench_row_t row;
    row = '{default: '0};
    row.kind = kind;
    row.user = user;
    row.elapsed = elapsed;
    row.typed = typed;
    row.want = '{granted: granted, level_tokens: level};
    directed_rows.push_back(row);
  endfunction

  function automatic void add_write(logic [CFG_IDX_W-1:0] index, logic [CFG_DATA_W-1:0] data);
    bench_row_t row;
    row = '{default: '0};
    row.is_cfg = 1'b1;
    row.cfg_index = index;
    row.cfg_data = data;
    directed_rows.push_back(row);
  endfunction

  // Main sequence.
  initial begin : stimulus
    logic [SIZE_W-1:0]     size_pick;
    logic [PERIOD_W-1:0]   period_pick;
    logic [REQ_W-1:0]      kind;
    logic [USER_IDX_W-1:0] user;
    logic [ELAPSED_W-1:0]  elapsed;
    int                    gap;
    int                    pick;

    rst = 1'b1;
    req_ch.valid = 1'b0;
    req_ch.req_type = REQ_TICK;
    req_ch.user_index = '0;
    req_ch.elapsed_us = '0;
    rsp_ch.ready = 1'b0;
    cfg_ch.valid = 1'b0;
    cfg_ch.index = CFG_BUCKET_SIZE;
    cfg_ch.data = '0;
    error_count = 0;
    cycle_count = 0;
    sender_calm = 1'b0;
    restore_defaults();

    // Directed table. Every bucket starts full at 50 tokens.
    add_item(REQ_REPORT, 4'd0,  32'd0,          1, 1'b0, 16'd50);
    add_item(REQ_GET,    4'd0,  32'd0,          1, 1'b1, 16'd49);
    add_item(REQ_GET,    4'd15, 32'hFFFF_FFFF,  1, 1'b1, 16'd49);
    add_item(REQ_TICK,   4'd0,  32'd0,          1, 1'b0, 16'd49);
    add_item(REQ_TICK,   4'd15, 32'd200000,     1, 1'b0, 16'd50);
    add_item(REQ_INIT,   4'd7,  32'd0,          1, 1'b0, 16'd50);
    // A lowered size leaves levels alone until the next tick caps them.
    add_write(CFG_BUCKET_SIZE, 32'd10);
    add_item(REQ_GET,    4'd3,  32'd0,          1, 1'b1, 16'd49);
    add_item(REQ_TICK,   4'd3,  32'd0,          1, 1'b0, 16'd10);
    add_item(REQ_REPORT, 4'd9,  32'd0,          1, 1'b0, 16'd10);
    // A zero size empties on init and refuses every get.
    add_write(CFG_BUCKET_SIZE, 32'd0);
    add_item(REQ_INIT,   4'd5,  32'd0,          1, 1'b0, 16'd0);
    add_item(REQ_GET,    4'd5,  32'd0,          1, 1'b0, 16'd0);
    add_item(REQ_TICK,   4'd1,  32'hFFFF_FFFF,  1, 1'b0, 16'd0);
    // Largest size, and a zero period that counts as one microsecond.
    add_write(CFG_BUCKET_SIZE, 32'd65535);
    add_write(CFG_TOKEN_PERIOD, 32'd0);
    add_item(REQ_INIT,   4'd2,  32'd0,          1, 1'b0, 16'd65535);
    add_item(REQ_GET,    4'd2,  32'd0,          1, 1'b1, 16'd65534);
    add_item(REQ_TICK,   4'd4,  32'd1,          1, 1'b0, 16'd1);
    add_item(REQ_TICK,   4'd2,  32'hFFFF_FFFF,  1, 1'b0, 16'd65535);
    // Writes to unused indexes change nothing; then the largest period.
    add_write(CFG_LAST_UNUSED, 32'hFFFF_FFFF);
    add_write(CFG_TOKEN_PERIOD, 32'hFFFF_FFFF);
    add_item(REQ_GET,    4'd6,  32'd0,          1, 1'b1, 16'd65534);
    add_item(REQ_TICK,   4'd6,  32'hFFFF_FFFF,  0, 1'b0, 16'd0);
    add_write(CFG_TOKEN_PERIOD, 32'd3);
    add_item(REQ_TICK,   4'd0,  32'd7,          0, 1'b0, 16'd0);
    add_item(REQ_GET,    4'd0,  32'd0,          0, 1'b0, 16'd0);

    repeat (10) @(posedge clk);
    rst <= 1'b0;

    foreach (directed_rows[i]) begin
      if (directed_rows[i].is_cfg) begin
        write_register(directed_rows[i].cfg_index, directed_rows[i].cfg_data);
      end else begin
        send_item(directed_rows[i].kind, directed_rows[i].user, directed_rows[i].elapsed,
                  $urandom_range(0, 2), directed_rows[i].typed, directed_rows[i].want);
      end
    end

    // Random phases, each under a fresh size and period.
    for (int phase = 0; phase < PHASES; phase++) begin
      case ($urandom_range(0, 6))
        0:       size_pick = 16'd0;
        1:       size_pick = 16'd1;
        2:       size_pick = 16'hFFFF;
        3, 4:    size_pick = 16'($urandom_range(2, 64));
        5:       size_pick = 16'($urandom_range(65, 65535));
        default: size_pick = 16'(RESET_SIZE);
      endcase
      // The first phases pin the extremes, later ones pick at random.
      if (phase == 0) size_pick = 16'd1;
      if (phase == 1) size_pick = 16'hFFFF;
      case ($urandom_range(0, 6))
        0:       period_pick = 32'd0;
        1:       period_pick = 32'd1;
        2:       period_pick = 32'hFFFF_FFFF;
        3:       period_pick = 32'($urandom_range(1, 1000));
        4:       period_pick = 32'(RESET_PERIOD);
        5:       period_pick = $urandom();
        default: period_pick = 32'($urandom_range(1000, 1000000));
      endcase
      if (phase == 0) period_pick = 32'd1;
      if (phase == 1) period_pick = 32'hFFFF_FFFF;
      // Upper data bits above the size field are ignored by the block.
      write_register(CFG_BUCKET_SIZE,
                     {($urandom_range(0, 1) == 1) ? 16'($urandom()) : 16'd0, size_pick});
      write_register(CFG_TOKEN_PERIOD, period_pick);
      if ($urandom_range(0, 3) == 0) begin
        write_register(4'($urandom_range(int'(CFG_FIRST_UNUSED), int'(CFG_LAST_UNUSED))),
                       $urandom());
      end
      sender_calm = ($urandom_range(0, 3) == 0);

      for (int n = 0; n < PHASE_ITEMS; n++) begin
        pick = $urandom_range(0, 99);
        if (pick < 55) kind = REQ_GET;
        else if (pick < 77) kind = REQ_TICK;
        else if (pick < 90) kind = REQ_INIT;
        else kind = REQ_REPORT;
        // Most traffic goes to a few users so their buckets run dry.
        user = ($urandom_range(0, 9) < 7) ? 4'($urandom_range(0, 3))
                                          : 4'($urandom_range(0, USERS - 1));
        case ($urandom_range(0, 7))
          0:       elapsed = 32'd0;
          1:       elapsed = $urandom();
          2:       elapsed = 32'hFFFF_FFFF;
          3, 4, 5: elapsed = (period_reg >> $urandom_range(0, 3)) + 32'($urandom_range(0, 3));
          default: elapsed = 32'($urandom_range(0, 1000));
        endcase
        pick = $urandom_range(0, 99);
        if (sender_calm || pick < 60) gap = 0;
        else if (pick < 90) gap = $urandom_range(1, 3);
        else if (pick < 98) gap = $urandom_range(4, 10);
        else gap = $urandom_range(30, 80);
        send_item(kind, user, elapsed, gap, 1'b0, '0);
        // Now and then hold the sender until every result is back.
        if ($urandom_range(0, 63) == 0) begin
          drain_results();
        end
      end
    end

    drain_results();
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (error_count == 0 && awaited_results.size() == 0) begin
      $display("testbench: done, clean");
    end else begin
      $display("testbench: done, errors");
    end
    $finish;
  end

endmodule
